// ===== design/cele90_pkg.sv =====
// ----------------------------------------------------------------------------
// cele90_pkg
// shared constants and the result record of the ce90 / le90 pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cele90_pkg;

	// default number of fraction bits of the fixed-point ports
	localparam int DEF_FRAC_BITS = 16;

	// polynomial and scale coefficients, 24 fraction bits
	localparam int K_SHIFT = 24;
	localparam int K0_W    = 25;
	localparam int K1_W    = 22;
	localparam int K2_W    = 24;
	localparam int KLE_W   = 25;
	localparam logic [K0_W-1:0]  K0_C  = 25'd27757904;
	localparam logic [K1_W-1:0]  K1_C  = 22'd2334214;
	localparam logic [K2_W-1:0]  K2_C  = 24'd10609911;
	localparam logic [KLE_W-1:0] KLE_C = 25'd27596843;

	// discriminant and its root
	localparam int W_W  = 66;
	localparam int B2_W = W_W / 2;

	// axis ratio is kept below 2^11; larger ratios always saturate ce90
	localparam int C_W      = 35;
	localparam int CLAMP_SH = C_W - K_SHIFT;
	localparam int C2_W     = 2 * C_W - K_SHIFT;
	localparam int T1_W     = K1_W + C_W - K_SHIFT;
	localparam int T2_W     = K2_W + C2_W - K_SHIFT;
	localparam int S_W      = T2_W + 1;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] ce90;
		logic [31:0] le90;
		logic        degenerate;
	} result_t;

endpackage

// ===== design/ce90_le90_from_covariance.sv =====
// ----------------------------------------------------------------------------
// ce90_le90_from_covariance
// ce90 and le90 pass a chain of square root, divider and split multiplier
//   stages, each square root and divider stage giving one result bit
// throughput: one item per cycle; the pipeline halts as a whole only when the
//   two-entry output buffer is full
// reset: arst_n clears all valid bits and the output buffer; no data reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ce90_le90_from_covariance import cele90_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        var_east,
	input  logic [31:0]        var_north,
	input  logic signed [31:0] cov_east_north,
	input  logic [31:0]        var_up,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        ce90,
	output logic [31:0]        le90,
	output logic               degenerate
);

	// width of the axis and sigma square roots, input padded to even
	localparam int SQ_W  = ((FRAC_BITS + 34) / 2) * 2;
	localparam int HW    = SQ_W / 2;
	localparam int NUM_W = HW + K_SHIFT;
	localparam int OV_W  = HW + CLAMP_SH;
	localparam int DSB_W = 2 * HW + 2;
	localparam int KSB_W = T1_W + 2 * HW + 2;
	localparam int PP_W  = S_W + HW;
	localparam int LP_W  = KLE_W + HW;

	// whole pipeline advances while the output buffer has room
	logic en;
	logic full;

	// stage 1: absolute differences and the trace
	logic [31:0] cov_raw;
	logic        vld_s1;
	logic [31:0] cabs_s1;
	logic [31:0] dabs_s1;
	logic [32:0] a2_s1;
	logic [31:0] u_s1;

	// stage 2: squares
	logic        vld_s2;
	logic [63:0] d2_s2;
	logic [63:0] csq_s2;
	logic [32:0] a2_s2;
	logic [31:0] u_s2;

	// stage 3: discriminant (E-N)^2 + 4C^2
	logic           vld_s3;
	logic [W_W-1:0] w_s3;
	logic [32:0]    a2_s3;
	logic [31:0]    u_s3;

	// discriminant root
	logic            b_valid;
	logic [B2_W-1:0] b2_root;
	logic [64:0]     b_sb;
	logic [32:0]     b_a2;
	logic [31:0]     b_u;

	// stage 4: eigenvalue sums, scaled for the axis roots
	logic            vld_s4;
	logic            degen_s4;
	logic [SQ_W-1:0] plus_s4;
	logic [SQ_W-1:0] minus_s4;
	logic [SQ_W-1:0] uin_s4;

	// axis and sigma roots
	logic          su_valid;
	logic [HW-1:0] su_root;
	logic [HW-1:0] sv_root;
	logic [HW-1:0] sig_root;
	logic          su_degen;
	logic [HW-1:0] sv_nz;

	// stage 5: divider operands and the ratio clamp
	logic          vld_s5;
	logic [HW-1:0] su_s5;
	logic [HW-1:0] sv_s5;
	logic [HW-1:0] sig_s5;
	logic          degen_s5;
	logic          ovf_s5;

	// ratio c = su / sv with 24 fraction bits
	logic             d_valid;
	logic [C_W-1:0]   c_quo;
	logic [DSB_W-1:0] d_sb;

	// c^2 and K1*c
	logic              cc_valid;
	logic [2*C_W-1:0]  cc_prod;
	logic [DSB_W-1:0]  cc_sb;
	logic [K1_W+C_W-1:0] k1_prod;

	// stage 6
	logic            vld_s6;
	logic [C2_W-1:0] c2_s6;
	logic [T1_W-1:0] t1_s6;
	logic [HW-1:0]   su_s6;
	logic [HW-1:0]   sig_s6;
	logic            degen_s6;
	logic            ovf_s6;

	// K2*c^2
	logic                 k2_valid;
	logic [K2_W+C2_W-1:0] k2_prod;
	logic [KSB_W-1:0]     k2_sb;
	logic [T2_W-1:0]      t2;
	logic [T1_W-1:0]      k2_t1;
	logic [HW-1:0]        k2_su;
	logic [HW-1:0]        k2_sig;
	logic                 k2_degen;
	logic                 k2_ovf;
	logic [S_W-1:0]       poly_sum;

	// stage 7: polynomial, floored at zero
	logic           vld_s7;
	logic [S_W-1:0] p_s7;
	logic [HW-1:0]  su_s7;
	logic [HW-1:0]  sig_s7;
	logic           degen_s7;
	logic           ovf_s7;

	// P*su and KLE*sigma
	logic            p_valid;
	logic [PP_W-1:0] p_prod;
	logic [1:0]      p_sb;
	logic [LP_W-1:0] le_prod;
	logic [PP_W-K_SHIFT-1:0] ce_sh;
	logic [LP_W-K_SHIFT-1:0] le_sh;
	result_t         res;
	result_t         out_res;

	assign en       = ~full;
	assign in_stall = full;
	assign cov_raw  = cov_east_north;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= b_valid;
			vld_s5 <= su_valid;
			vld_s6 <= cc_valid;
			vld_s7 <= k2_valid;
		end
	end

	// front end: |C|, |E-N|, E+N, then squares, then the discriminant
	always_ff @(posedge clk) begin
		if (en) begin
			cabs_s1 <= cov_raw[31] ? (~cov_raw + 32'd1) : cov_raw;
			dabs_s1 <= (var_east >= var_north) ? (var_east - var_north)
				: (var_north - var_east);
			a2_s1   <= 33'(var_east) + 33'(var_north);
			u_s1    <= var_up;

			d2_s2   <= 64'(dabs_s1) * 64'(dabs_s1);
			csq_s2  <= 64'(cabs_s1) * 64'(cabs_s1);
			a2_s2   <= a2_s1;
			u_s2    <= u_s1;

			w_s3    <= W_W'(d2_s2) + {csq_s2, 2'b00};
			a2_s3   <= a2_s2;
			u_s3    <= u_s2;
		end
	end

	cele90_isqrt #(
		.IN_W(W_W),
		.SB_W(65)
	) u_isqrt_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.in_val   (w_s3),
		.in_sb    ({a2_s3, u_s3}),
		.out_valid(b_valid),
		.out_root (b2_root),
		.out_sb   (b_sb)
	);

	assign b_a2 = b_sb[64:32];
	assign b_u  = b_sb[31:0];

	// the major eigenvalue doubled is a2+b2, the minor a2-b2; the extra
	// halving of the eigenvalue folds into the shift by FRAC_BITS-1
	always_ff @(posedge clk) begin
		if (en) begin
			degen_s4 <= (b_a2 <= b2_root);
			plus_s4  <= SQ_W'(34'(b_a2) + 34'(b2_root)) << (FRAC_BITS - 1);
			minus_s4 <= SQ_W'(b_a2 - b2_root) << (FRAC_BITS - 1);
			uin_s4   <= SQ_W'(b_u) << FRAC_BITS;
		end
	end

	cele90_isqrt #(
		.IN_W(SQ_W),
		.SB_W(1)
	) u_isqrt_su (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.in_val   (plus_s4),
		.in_sb    (degen_s4),
		.out_valid(su_valid),
		.out_root (su_root),
		.out_sb   (su_degen)
	);

	cele90_isqrt #(
		.IN_W(SQ_W),
		.SB_W(1)
	) u_isqrt_sv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.in_val   (minus_s4),
		.in_sb    (1'b0),
		.out_valid(),
		.out_root (sv_root),
		.out_sb   ()
	);

	cele90_isqrt #(
		.IN_W(SQ_W),
		.SB_W(1)
	) u_isqrt_sig (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.in_val   (uin_s4),
		.in_sb    (1'b0),
		.out_valid(),
		.out_root (sig_root),
		.out_sb   ()
	);

	// a zero minor axis divides by one
	assign sv_nz = (sv_root == '0) ? HW'(1) : sv_root;

	// ratio of 2^11 or more always saturates ce90, since su >= ratio and the
	// polynomial then exceeds 2^21; the divider only needs 35 quotient bits
	always_ff @(posedge clk) begin
		if (en) begin
			su_s5    <= su_root;
			sv_s5    <= sv_nz;
			sig_s5   <= sig_root;
			degen_s5 <= su_degen;
			ovf_s5   <= (OV_W'(su_root) >= (OV_W'(sv_nz) << CLAMP_SH));
		end
	end

	cele90_div #(
		.N_W (NUM_W),
		.D_W (HW),
		.Q_W (C_W),
		.SB_W(DSB_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.in_num   ({su_s5, {K_SHIFT{1'b0}}}),
		.in_den   (sv_s5),
		.in_sb    ({su_s5, sig_s5, degen_s5, ovf_s5}),
		.out_valid(d_valid),
		.out_quo  (c_quo),
		.out_sb   (d_sb)
	);

	cele90_mul #(
		.A_W (C_W),
		.B_W (C_W),
		.SB_W(DSB_W)
	) u_mul_cc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (d_valid),
		.in_a     (c_quo),
		.in_b     (c_quo),
		.in_sb    (d_sb),
		.out_valid(cc_valid),
		.out_prod (cc_prod),
		.out_sb   (cc_sb)
	);

	cele90_mul #(
		.A_W (K1_W),
		.B_W (C_W),
		.SB_W(1)
	) u_mul_k1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (d_valid),
		.in_a     (K1_C),
		.in_b     (c_quo),
		.in_sb    (1'b0),
		.out_valid(),
		.out_prod (k1_prod),
		.out_sb   ()
	);

	always_ff @(posedge clk) begin
		if (en) begin
			c2_s6    <= cc_prod[K_SHIFT +: C2_W];
			t1_s6    <= k1_prod[K_SHIFT +: T1_W];
			su_s6    <= cc_sb[DSB_W-1 -: HW];
			sig_s6   <= cc_sb[2 +: HW];
			degen_s6 <= cc_sb[1];
			ovf_s6   <= cc_sb[0];
		end
	end

	cele90_mul #(
		.A_W (K2_W),
		.B_W (C2_W),
		.SB_W(KSB_W)
	) u_mul_k2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s6),
		.in_a     (K2_C),
		.in_b     (c2_s6),
		.in_sb    ({t1_s6, su_s6, sig_s6, degen_s6, ovf_s6}),
		.out_valid(k2_valid),
		.out_prod (k2_prod),
		.out_sb   (k2_sb)
	);

	assign t2       = k2_prod[K_SHIFT +: T2_W];
	assign k2_t1    = k2_sb[KSB_W-1 -: T1_W];
	assign k2_su    = k2_sb[2 + HW +: HW];
	assign k2_sig   = k2_sb[2 +: HW];
	assign k2_degen = k2_sb[1];
	assign k2_ovf   = k2_sb[0];
	assign poly_sum = S_W'(t2) + S_W'(K0_C);

	// K0 + K2 c^2 - K1 c, never below zero
	always_ff @(posedge clk) begin
		if (en) begin
			p_s7     <= (poly_sum >= S_W'(k2_t1)) ? (poly_sum - S_W'(k2_t1)) : '0;
			su_s7    <= k2_su;
			sig_s7   <= k2_sig;
			degen_s7 <= k2_degen;
			ovf_s7   <= k2_ovf;
		end
	end

	cele90_mul #(
		.A_W (S_W),
		.B_W (HW),
		.SB_W(2)
	) u_mul_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s7),
		.in_a     (p_s7),
		.in_b     (su_s7),
		.in_sb    ({degen_s7, ovf_s7}),
		.out_valid(p_valid),
		.out_prod (p_prod),
		.out_sb   (p_sb)
	);

	cele90_mul #(
		.A_W (KLE_W),
		.B_W (HW),
		.SB_W(1)
	) u_mul_le (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s7),
		.in_a     (KLE_C),
		.in_b     (sig_s7),
		.in_sb    (1'b0),
		.out_valid(),
		.out_prod (le_prod),
		.out_sb   ()
	);

	assign ce_sh = p_prod[PP_W-1:K_SHIFT];
	assign le_sh = le_prod[LP_W-1:K_SHIFT];

	// final scaling with saturation to 32 bits; degenerate or clamped ratio
	// forces ce90 to all ones
	always_comb begin
		res.degenerate = p_sb[1];
		if (p_sb[1] || p_sb[0] || ((ce_sh >> 32) != '0)) begin
			res.ce90 = SAT32;
		end else begin
			res.ce90 = 32'(ce_sh);
		end
		if ((le_sh >> 32) != '0) begin
			res.le90 = SAT32;
		end else begin
			res.le90 = 32'(le_sh);
		end
	end

	cele90_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (en & p_valid),
		.push_data(res),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_res)
	);

	assign ce90       = out_res.ce90;
	assign le90       = out_res.le90;
	assign degenerate = out_res.degenerate;

endmodule

// ===== design/cele90_isqrt.sv =====
// ----------------------------------------------------------------------------
// cele90_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cele90_isqrt #(
	parameter int IN_W = 66,
	parameter int SB_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   in_val,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [IN_W/2-1:0] out_root,
	output logic [SB_W-1:0]   out_sb
);

	localparam int R = IN_W / 2;

	logic [IN_W-1:0] val_s  [R+1];
	logic [R-1:0]    root_s [R+1];
	logic [R+1:0]    rem_s  [R+1];
	logic [SB_W-1:0] sb_s   [R+1];
	logic [R:0]      vld_s;

	function automatic logic [R+1:0] rem_next(logic [R+1:0] rem, logic [R-1:0] root,
		logic [1:0] pair);
		logic [R+1:0] remw;
		logic [R+1:0] trial;
		begin
			remw = {rem[R-1:0], pair};
			trial = {root, 2'b01};
			rem_next = (remw >= trial) ? (remw - trial) : remw;
		end
	endfunction

	function automatic logic [R-1:0] root_next(logic [R+1:0] rem, logic [R-1:0] root,
		logic [1:0] pair);
		logic [R+1:0] remw;
		logic [R+1:0] trial;
		begin
			remw = {rem[R-1:0], pair};
			trial = {root, 2'b01};
			root_next = {root[R-2:0], (remw >= trial)};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[R-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s[0]  <= in_val;
			root_s[0] <= '0;
			rem_s[0]  <= '0;
			sb_s[0]   <= in_sb;
			for (int k = 0; k < R; k++) begin
				val_s[k+1]  <= val_s[k] << 2;
				rem_s[k+1]  <= rem_next(rem_s[k], root_s[k], val_s[k][IN_W-1 -: 2]);
				root_s[k+1] <= root_next(rem_s[k], root_s[k], val_s[k][IN_W-1 -: 2]);
				sb_s[k+1]   <= sb_s[k];
			end
		end
	end

	assign out_valid = vld_s[R];
	assign out_root  = root_s[R];
	assign out_sb    = sb_s[R];

endmodule

// ===== design/cele90_div.sv =====
// ----------------------------------------------------------------------------
// cele90_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cele90_div #(
	parameter int N_W  = 49,
	parameter int D_W  = 25,
	parameter int Q_W  = 35,
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [N_W-1:0]  in_num,
	input  logic [D_W-1:0]  in_den,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_valid,
	output logic [Q_W-1:0]  out_quo,
	output logic [SB_W-1:0] out_sb
);

	localparam int RW = D_W + 1;

	logic [RW-1:0]   rem_s [Q_W+1];
	logic [Q_W-1:0]  low_s [Q_W+1];
	logic [Q_W-1:0]  quo_s [Q_W+1];
	logic [D_W-1:0]  den_s [Q_W+1];
	logic [SB_W-1:0] sb_s  [Q_W+1];
	logic [Q_W:0]    vld_s;

	// quotient is assumed to fit in Q_W bits, so the upper part starts below den
	function automatic logic [RW-1:0] rem_next(logic [RW-1:0] rem, logic nb,
		logic [D_W-1:0] den);
		logic [RW-1:0] remw;
		begin
			remw = {rem[RW-2:0], nb};
			rem_next = (remw >= {1'b0, den}) ? (remw - {1'b0, den}) : remw;
		end
	endfunction

	function automatic logic [Q_W-1:0] quo_next(logic [RW-1:0] rem, logic nb,
		logic [D_W-1:0] den, logic [Q_W-1:0] quo);
		logic [RW-1:0] remw;
		begin
			remw = {rem[RW-2:0], nb};
			quo_next = {quo[Q_W-2:0], (remw >= {1'b0, den})};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[Q_W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(in_num >> Q_W);
			low_s[0] <= in_num[Q_W-1:0];
			quo_s[0] <= '0;
			den_s[0] <= in_den;
			sb_s[0]  <= in_sb;
			for (int k = 0; k < Q_W; k++) begin
				rem_s[k+1] <= rem_next(rem_s[k], low_s[k][Q_W-1], den_s[k]);
				quo_s[k+1] <= quo_next(rem_s[k], low_s[k][Q_W-1], den_s[k], quo_s[k]);
				low_s[k+1] <= low_s[k] << 1;
				den_s[k+1] <= den_s[k];
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign out_quo   = quo_s[Q_W];
	assign out_sb    = sb_s[Q_W];

endmodule

// ===== design/cele90_mul.sv =====
// ----------------------------------------------------------------------------
// cele90_mul
// three-stage multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cele90_mul #(
	parameter int A_W  = 35,
	parameter int B_W  = 35,
	parameter int SB_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [A_W-1:0]     in_a,
	input  logic [B_W-1:0]     in_b,
	input  logic [SB_W-1:0]    in_sb,
	output logic               out_valid,
	output logic [A_W+B_W-1:0] out_prod,
	output logic [SB_W-1:0]    out_sb
);

	localparam int AL  = A_W / 2;
	localparam int AH  = A_W - AL;
	localparam int BL  = B_W / 2;
	localparam int BH  = B_W - BL;
	localparam int P_W = A_W + B_W;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;
	logic [P_W-1:0]   x1_s2;
	logic [P_W-1:0]   x2_s2;
	logic [P_W-1:0]   prod_s3;
	logic [SB_W-1:0]  sb_s1;
	logic [SB_W-1:0]  sb_s2;
	logic [SB_W-1:0]  sb_s3;
	logic [2:0]       vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1   <= (AL+BL)'(in_a[AL-1:0]) * (AL+BL)'(in_b[BL-1:0]);
			lh_s1   <= (AL+BH)'(in_a[AL-1:0]) * (AL+BH)'(in_b[B_W-1:BL]);
			hl_s1   <= (AH+BL)'(in_a[A_W-1:AL]) * (AH+BL)'(in_b[BL-1:0]);
			hh_s1   <= (AH+BH)'(in_a[A_W-1:AL]) * (AH+BH)'(in_b[B_W-1:BL]);
			sb_s1   <= in_sb;
			x1_s2   <= P_W'(ll_s1) + (P_W'(lh_s1) << BL);
			x2_s2   <= (P_W'(hl_s1) << AL) + (P_W'(hh_s1) << (AL + BL));
			sb_s2   <= sb_s1;
			prod_s3 <= x1_s2 + x2_s2;
			sb_s3   <= sb_s2;
		end
	end

	assign out_valid = vld_s[2];
	assign out_prod  = prod_s3;
	assign out_sb    = sb_s3;

endmodule

// ===== design/cele90_obuf.sv =====
// ----------------------------------------------------------------------------
// cele90_obuf
// two-entry output buffer that parts the pipeline from the output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cele90_obuf import cele90_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    v0_q;
	logic    v1_q;
	result_t d0_q;
	result_t d1_q;
	logic    pop;

	assign pop = v0_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= push | v1_q | (v0_q & ~pop);
			if (pop) begin
				v1_q <= 1'b0;
			end else if (push && v0_q) begin
				v1_q <= 1'b1;
			end
		end
	end

	// push only happens while the second entry is free
	always_ff @(posedge clk) begin
		if (push && (!v0_q || pop)) begin
			d0_q <= push_data;
		end else if (pop) begin
			d0_q <= d1_q;
		end
		if (push && v0_q && !pop) begin
			d1_q <= push_data;
		end
	end

	assign full      = v1_q;
	assign out_valid = v0_q;
	assign out_data  = d0_q;

endmodule
